// ===== sv/bsc_pkg.sv =====
// Shared widths, register indexes and the microcode table of the compensation sequencer.
`default_nettype none

package bsc_pkg;

  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 27;
  localparam int COEFF_W   = 16;
  localparam int NUM_COEFF = 6;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int DT_W   = RAW_W + 1;
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 48;
  localparam int STEP_W = 4;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

  localparam int TEMP_BASE     = 2000;
  localparam int TEMP_XLOW_OFS = 3500;   // t + 1500 expressed from t - 2000
  localparam int PRES_RESET    = -100;
  localparam int PRES_SHIFT    = 15;

  localparam logic [STEP_W-1:0] STEP_PRESS = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd12;

  typedef enum logic [3:0] {
    MS_HOLD,
    MS_DT_C6,
    MS_C4_DT,
    MS_C3_DT,
    MS_DT_DT,
    MS_D_5D,
    MS_E_7E,
    MS_E_11E,
    MS_RAW_LO,
    MS_RAW_HI
  } mul_sel_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_D,
    DST_T2,
    DST_OFF,
    DST_SENS,
    DST_PRES_INIT,
    DST_PRES
  } dst_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_T_NOT_LOW,
    JMP_T_NOT_VLOW
  } jmp_e;

  typedef struct packed {
    mul_sel_e          msel;
    dst_e              dst;
    logic              sub;
    logic [4:0]        shamt;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{msel: MS_HOLD, dst: DST_NONE, sub: 1'b0, shamt: 5'd0, jmp: JMP_NONE, target: '0};
    case (step)
      4'd0: begin
        uw.msel = MS_DT_C6;
      end
      4'd1: begin
        uw.msel = MS_C4_DT;  uw.dst = DST_D;     uw.shamt = 5'd23;
      end
      4'd2: begin
        uw.msel = MS_C3_DT;  uw.dst = DST_OFF;   uw.shamt = 5'd7;
      end
      4'd3: begin
        uw.msel = MS_DT_DT;  uw.dst = DST_SENS;  uw.shamt = 5'd8;
        uw.jmp  = JMP_T_NOT_LOW;  uw.target = STEP_PRESS;
      end
      4'd4: begin
        uw.msel = MS_D_5D;   uw.dst = DST_T2;    uw.shamt = 5'd31;
      end
      4'd5: begin
        uw.dst = DST_OFF;    uw.sub = 1'b1;      uw.shamt = 5'd1;
      end
      4'd6: begin
        uw.msel = MS_E_7E;   uw.dst = DST_SENS;  uw.sub = 1'b1;  uw.shamt = 5'd2;
        uw.jmp  = JMP_T_NOT_VLOW; uw.target = STEP_PRESS;
      end
      4'd7: begin
        uw.msel = MS_E_11E;  uw.dst = DST_OFF;   uw.sub = 1'b1;
      end
      4'd8: begin
        uw.dst = DST_SENS;   uw.sub = 1'b1;      uw.shamt = 5'd1;
      end
      4'd9: begin
        uw.msel = MS_RAW_LO;
      end
      4'd10: begin
        uw.msel = MS_RAW_HI; uw.dst = DST_PRES_INIT; uw.shamt = 5'd21;
      end
      4'd11: begin
        uw.dst = DST_PRES;
      end
      default: begin
        uw.msel = MS_HOLD;
      end
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bsc_if.sv =====
// Valid/ready channel interfaces for raw readings and compensated results.
`default_nettype none

interface bsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsc_pkg::RAW_W-1:0]   adc_reading;

  modport source (output valid, output adc_reading, input ready);
  modport sink   (input valid, input adc_reading, output ready);
endinterface

interface bsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsc_pkg::TEMP_W-1:0]  temp_centi;
  logic signed [bsc_pkg::PRES_W-1:0]  pressure_pa;
  logic                               fresh;

  modport source (output valid, output temp_centi, output pressure_pa, output fresh,
                  input ready);
  modport sink   (input valid, input temp_centi, input pressure_pa, input fresh,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/baro_sensor_compensation.sv =====
// Top level: second-order barometric compensation run by a microcoded sequencer.
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ----------------------------------------------
//  in_if     in   valid/ready        adc_reading (24b, pressure/temperature alternate)
//  out_if    out  valid/ready        temp_centi (19b s), pressure_pa (27b s), fresh
//  cfg       in   cfg_we_i only      cfg_idx_i (3b), cfg_data_i (16b), C1..C6
//
//  A pressure reading is held and its result (last values, fresh = 0) is presented
//  the cycle after the transfer. A temperature reading runs the microprogram on one
//  26x26 multiplier, one step a cycle (the last waits out a stalled result):
//  8 steps at or above 20.00 C, 11 below it and 13 below -15.00 C.
//  Reset clears coefficients, phase, held pressure and the last results (0 / -100).
//  Hold the input while the sequencer runs or a stalled result waits to drain.
`default_nettype none

module baro_sensor_compensation (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bsc_pkg::COEFF_W-1:0]     cfg_data_i,
  bsc_in_if.sink                               in_if,
  bsc_out_if.source                            out_if
);
  import bsc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Control state
  logic                      state_q, state_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      phase_q;
  logic                      out_valid_q;
  logic                      fresh_q;
  logic [COEFF_W-1:0]        coeff_q [NUM_COEFF];
  logic [RAW_W-1:0]          held_q;
  logic signed [TEMP_W-1:0]  last_temp_q;
  logic signed [PRES_W-1:0]  last_pres_q;

  // Datapath registers
  logic signed [DT_W-1:0]    dt_q;
  logic signed [TEMP_W-1:0]  d_q;      // t - 2000
  logic [TEMP_W-1:0]         t2_q;
  logic signed [ACC_W-1:0]   off_q;
  logic signed [ACC_W-1:0]   sens_q;
  logic signed [ACC_W-1:0]   pres_q;
  logic signed [PROD_W-1:0]  prod_q;

  ucode_t                    uw;
  logic                      in_xfer;
  logic                      out_free;
  logic                      run_step;
  logic                      finish;
  logic                      jmp_take;

  logic signed [MUL_W-1:0]   dt_w, d_w, d5_w, e_w, e7_w, e11_w;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  term_full;
  logic signed [ACC_W-1:0]   term;
  logic signed [TEMP_W+1:0]  temp_full;
  logic signed [ACC_W-1:0]   pres_full;

  // Handshake
  assign out_free     = !out_valid_q || out_if.ready;
  assign in_if.ready  = (state_q == ST_IDLE) && out_free;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign run_step     = (state_q == ST_RUN) && (step_q != STEP_LAST);
  assign finish       = (state_q == ST_RUN) && (step_q == STEP_LAST) && out_free;

  assign out_if.valid       = out_valid_q;
  assign out_if.temp_centi  = last_temp_q;
  assign out_if.pressure_pa = last_pres_q;
  assign out_if.fresh       = fresh_q;

  // Microcode fetch
  assign uw = ucode_rom(step_q);

  // Operand preparation: small scalings of d and e = t + 1500 feed the squares
  assign dt_w  = {dt_q[DT_W-1], dt_q};
  assign d_w   = {{(MUL_W-TEMP_W){d_q[TEMP_W-1]}}, d_q};
  assign d5_w  = (d_w <<< 2) + d_w;
  assign e_w   = d_w + MUL_W'(TEMP_XLOW_OFS);
  assign e7_w  = (e_w <<< 3) - e_w;
  assign e11_w = (e_w <<< 3) + (e_w <<< 1) + e_w;

  always_comb begin
    op_a = dt_w;
    op_b = dt_w;
    case (uw.msel)
      MS_DT_C6: begin
        op_a = dt_w;
        op_b = $signed({{(MUL_W-COEFF_W){1'b0}}, coeff_q[CFG_C6]});
      end
      MS_C4_DT: begin
        op_a = $signed({{(MUL_W-COEFF_W){1'b0}}, coeff_q[CFG_C4]});
        op_b = dt_w;
      end
      MS_C3_DT: begin
        op_a = $signed({{(MUL_W-COEFF_W){1'b0}}, coeff_q[CFG_C3]});
        op_b = dt_w;
      end
      MS_DT_DT: begin
        op_a = dt_w;
        op_b = dt_w;
      end
      MS_D_5D: begin
        op_a = d_w;
        op_b = d5_w;
      end
      MS_E_7E: begin
        op_a = e_w;
        op_b = e7_w;
      end
      MS_E_11E: begin
        op_a = e_w;
        op_b = e11_w;
      end
      MS_RAW_LO: begin
        // low 21 bits of sensitivity, unsigned
        op_a = $signed({{(MUL_W-RAW_W){1'b0}}, held_q});
        op_b = $signed({{(MUL_W-21){1'b0}}, sens_q[20:0]});
      end
      MS_RAW_HI: begin
        // sensitivity floor-shifted by 21
        op_a = $signed({{(MUL_W-RAW_W){1'b0}}, held_q});
        op_b = sens_q[MUL_W+20:21];
      end
      default: begin
        op_a = dt_w;
        op_b = dt_w;
      end
    endcase
  end

  assign prod_d    = op_a * op_b;
  assign term_full = prod_q >>> uw.shamt;
  assign term      = term_full[ACC_W-1:0];

  always_comb begin
    case (uw.jmp)
      JMP_T_NOT_LOW:  jmp_take = !d_q[TEMP_W-1];
      JMP_T_NOT_VLOW: jmp_take = !e_w[MUL_W-1];
      default:        jmp_take = 1'b0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && phase_q) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (run_step) begin
          step_d = jmp_take ? uw.target : step_q + 1'b1;
        end else if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Results: t - t2 and the floor-shifted pressure
  assign temp_full = (TEMP_W+2)'(TEMP_BASE) + {{2{d_q[TEMP_W-1]}}, d_q}
                   - $signed({2'b0, t2_q});
  assign pres_full = pres_q >>> PRES_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
      held_q      <= '0;
      last_temp_q <= '0;
      last_pres_q <= PRES_W'(PRES_RESET);
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;

      // Drop indexes past the last coefficient
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEFF))) begin
        coeff_q[cfg_idx_i] <= cfg_data_i;
      end

      // Present a new result, else drop the one that transfers
      if ((in_xfer && !phase_q) || finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        phase_q <= !phase_q;
        if (!phase_q) begin
          // Pressure: hold the raw value and repeat the last result
          held_q  <= in_if.adc_reading;
          fresh_q <= 1'b0;
        end
      end

      if (finish) begin
        last_temp_q <= temp_full[TEMP_W-1:0];
        last_pres_q <= pres_full[PRES_W-1:0];
        fresh_q     <= 1'b1;
      end
    end
  end

  // Datapath: loaded on a temperature transfer, advanced one control word a cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer && phase_q) begin
      dt_q   <= $signed({1'b0, in_if.adc_reading})
              - $signed({1'b0, coeff_q[CFG_C5], 8'b0});
      off_q  <= $signed({{(ACC_W-COEFF_W-16){1'b0}}, coeff_q[CFG_C2], 16'b0});
      sens_q <= $signed({{(ACC_W-COEFF_W-15){1'b0}}, coeff_q[CFG_C1], 15'b0});
      t2_q   <= '0;
    end else if (run_step) begin
      if (uw.msel != MS_HOLD) begin
        prod_q <= prod_d;
      end
      case (uw.dst)
        DST_D:         d_q    <= term[TEMP_W-1:0];
        DST_T2:        t2_q   <= term[TEMP_W-1:0];
        DST_OFF:       off_q  <= uw.sub ? off_q - term : off_q + term;
        DST_SENS:      sens_q <= uw.sub ? sens_q - term : sens_q + term;
        DST_PRES_INIT: pres_q <= term - off_q;
        DST_PRES:      pres_q <= pres_q + term;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_LAST))
    else $error("sequencer step past program end");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !in_if.ready)
    else $error("input ready while sequencer busy");

  a_fresh_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.fresh != phase_q))
    else $error("result freshness disagrees with reading phase");

  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && fresh_q && (state_q == ST_IDLE)))
    else $error("finished computation not presented");
`endif

endmodule

`default_nettype wire

// ===== tb/baro_sensor_compensation_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the barometric compensation block with a built-in predictor.
module baro_sensor_compensation_tb;
  import bsc_pkg::*;

  // Indexes past the last calibration word; the block must drop writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  // Compensation thresholds in hundredths of a degree.
  localparam longint T_REF  = 2000;
  localparam longint T_VLOW = -1500;
  localparam int PRES_BEFORE_FIRST = -100;

  // Settle time after a drain, with margin over the longest temperature computation.
  localparam int DRAIN_CYCLES = 20;
  // One long receiver hold-off, started once this many results have come.
  localparam int HOLD_AT   = 300;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_pa;
    logic                     fresh;
  } baro_result_t;

  typedef logic [COEFF_W-1:0] cal_set_t [NUM_COEFF];

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals that drive the block. Every input starts known.
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [COEFF_W-1:0]   cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic [RAW_W-1:0]     in_reading = '0;
  logic                 out_ready  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bsc_in_if  in_ch ();
  bsc_out_if out_ch ();

  assign in_ch.valid       = in_valid;
  assign in_ch.adc_reading = in_reading;
  assign out_ch.ready      = out_ready;

  baro_sensor_compensation i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: calibration copy, phase, held pressure, last results.
  // ---------------------------------------------------------------------------
  logic [COEFF_W-1:0]       cal_word [NUM_COEFF];
  logic                     temp_due     = 1'b0;
  logic [RAW_W-1:0]         held_press   = '0;
  logic signed [TEMP_W-1:0] last_temp_c  = '0;
  logic signed [PRES_W-1:0] last_pres_pa = PRES_W'(PRES_BEFORE_FIRST);

  baro_result_t     expected_results [$];
  logic [RAW_W-1:0] pending_readings [$];

  // Bookkeeping shared between the processes.
  bit          in_fired  = 1'b0;   // input transfer at the last rising edge
  bit          drv_busy  = 1'b0;   // driver is offering a reading
  bit          gen_temp  = 1'b0;   // next generated reading is a temperature
  bit          hold_done = 1'b0;
  int          in_gap    = 0;
  int          in_calm   = 0;
  int          out_stall = 0;
  int          out_calm  = 0;
  int unsigned n_in, n_out, n_comp, n_low, n_vlow, n_cal_sets, mismatches;

  // Gap length for either side: mostly none or short, a few long, and now
  // and then a calm streak with no gaps at all.
  function automatic int draw_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the predictor by one accepted reading and queue its result.
  task automatic predict_reading(input logic [RAW_W-1:0] raw);
    longint c1, c2, c3, c4, c5, c6;
    longint dt, t, t2, off2, sens2, sq, off, sens, p, tc;
    baro_result_t r;
    r.fresh = 1'b0;
    if (!temp_due) begin
      // Pressure reading: hold the raw value, repeat the last results.
      held_press = raw;
      temp_due   = 1'b1;
    end else begin
      c1 = longint'(cal_word[CFG_C1]);
      c2 = longint'(cal_word[CFG_C2]);
      c3 = longint'(cal_word[CFG_C3]);
      c4 = longint'(cal_word[CFG_C4]);
      c5 = longint'(cal_word[CFG_C5]);
      c6 = longint'(cal_word[CFG_C6]);
      // All shifts on signed 64-bit values are arithmetic, i.e. floor division.
      dt    = longint'(raw) - (c5 <<< 8);
      t     = T_REF + ((dt * c6) >>> 23);
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      if (t < T_REF) begin
        // Second-order terms below 20.00 C.
        n_low++;
        t2    = (dt * dt) >>> 31;
        sq    = (t - T_REF) * (t - T_REF);
        off2  = (5 * sq) >>> 1;
        sens2 = (5 * sq) >>> 2;
        if (t < T_VLOW) begin
          // Extra term below -15.00 C.
          n_vlow++;
          sq    = (t - T_VLOW) * (t - T_VLOW);
          off2  = off2 + 7 * sq;
          sens2 = sens2 + ((11 * sq) >>> 1);
        end
      end
      off  = (c2 <<< 16) + ((c4 * dt) >>> 7) - off2;
      sens = (c1 <<< 15) + ((c3 * dt) >>> 8) - sens2;
      p    = (((longint'(held_press) * sens) >>> 21) - off) >>> 15;
      tc   = t - t2;
      last_temp_c  = tc[TEMP_W-1:0];
      last_pres_pa = p[PRES_W-1:0];
      temp_due = 1'b0;
      r.fresh  = 1'b1;
      n_comp++;
    end
    r.temp_centi  = last_temp_c;
    r.pressure_pa = last_pres_pa;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Predict the input
  // transfer first so that an expectation is always in place before its result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    baro_result_t want;
    in_fired = rst_n && in_valid && in_ch.ready;
    if (in_fired) begin
      predict_reading(in_reading);
      n_in++;
    end
    if (rst_n && out_ch.valid && out_ready) begin
      n_out++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual temp %0d pressure %0d fresh %0b",
                 $time, out_ch.temp_centi, out_ch.pressure_pa, out_ch.fresh);
      end else begin
        want = expected_results.pop_front();
        check_field("temp_centi", want.temp_centi, out_ch.temp_centi);
        check_field("pressure_pa", want.pressure_pa, out_ch.pressure_pa);
        check_field("fresh", {63'd0, want.fresh}, {63'd0, out_ch.fresh});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold the reading until its
  // transfer, then draw a gap before offering the next one.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (drv_busy && in_fired) drv_busy = 1'b0;
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          in_reading <= pending_readings.pop_front();
          in_valid   <= 1'b1;
          drv_busy   = 1'b1;
          in_gap     = draw_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up and
  // stalls its input while the driver keeps offering.
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (!hold_done && n_out >= HOLD_AT) begin
      hold_done = 1'b1;
      out_stall = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      g = draw_gap(out_calm);
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_stall = g - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers, called from the sequence below only.
  // ---------------------------------------------------------------------------
  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx <= CFG_C6) cal_word[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write all six words, then poke both spare indexes with junk.
  task automatic load_cal(input cal_set_t plan);
    for (int i = 0; i < NUM_COEFF; i++) write_cal(CFG_IDX_W'(i), plan[i]);
    write_cal(CFG_SPARE_LO, COEFF_W'($urandom()));
    write_cal(CFG_SPARE_HI, COEFF_W'($urandom()));
    n_cal_sets++;
  endtask

  task automatic queue_pair(input logic [RAW_W-1:0] press, input logic [RAW_W-1:0] temp);
    pending_readings.push_back(press);
    pending_readings.push_back(temp);
  endtask

  // Random readings. Bias temperatures around the reference so that the
  // first-order, low and very-low branches all see plenty of traffic.
  task automatic queue_readings(input int count);
    logic [RAW_W-1:0] raw;
    longint centre;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        raw = '0;
      end else if (pick == 1) begin
        raw = RAW_MAX;
      end else if (gen_temp && pick <= 4) begin
        centre = (longint'(cal_word[CFG_C5]) <<< 8)
                 + longint'($urandom_range(0, 4194304)) - 2097152;
        if (centre < 0) centre = 0;
        else if (centre > longint'(RAW_MAX)) centre = longint'(RAW_MAX);
        raw = centre[RAW_W-1:0];
      end else begin
        raw = RAW_W'($urandom());
      end
      pending_readings.push_back(raw);
      gen_temp = !gen_temp;
    end
  endtask

  // Wait until every reading is in and every result is out, then let the
  // pipeline settle before anything touches the calibration words.
  task automatic wait_drained();
    while (pending_readings.size() != 0 || drv_busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed readings, then random phases under several
  // calibration sets.
  // ---------------------------------------------------------------------------
  localparam cal_set_t CAL_TYPICAL = '{16'd40127, 16'd36924, 16'd23317,
                                       16'd23282, 16'd33464, 16'd28312};

  initial begin
    cal_set_t plan;
    longint zero_dt_raw;
    for (int i = 0; i < NUM_COEFF; i++) cal_word[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration (all zero): first result must be 0 / -100, not fresh.
    queue_pair('0, '0);
    queue_pair(RAW_MAX, RAW_MAX);
    queue_pair(RAW_W'($urandom()), RAW_W'($urandom()));
    wait_drained();

    // Slope of one count per 256 raw counts puts the thresholds on exact codes.
    plan = CAL_TYPICAL;
    plan[CFG_C6] = 16'd32768;
    load_cal(plan);
    zero_dt_raw = longint'(cal_word[CFG_C5]) <<< 8;
    queue_pair(RAW_MAX, RAW_W'(zero_dt_raw));            // exactly 20.00 C
    queue_pair(RAW_MAX, RAW_W'(zero_dt_raw - 1));        // just below 20.00 C
    queue_pair(24'h800000, RAW_W'(zero_dt_raw - 896000)); // exactly -15.00 C
    queue_pair(RAW_MAX, RAW_W'(zero_dt_raw - 896001));   // just below -15.00 C
    queue_pair('0, RAW_MAX);
    queue_pair(RAW_MAX, '0);
    wait_drained();

    plan = '{default: '1};
    load_cal(plan);
    queue_readings(110);
    wait_drained();

    plan = '{default: '0};
    load_cal(plan);
    queue_readings(60);
    wait_drained();

    // The long receiver hold-off falls into this phase.
    load_cal(CAL_TYPICAL);
    queue_readings(150);
    wait_drained();

    repeat (4) begin
      foreach (plan[i]) plan[i] = COEFF_W'($urandom());
      load_cal(plan);
      queue_readings(80);
      wait_drained();
    end

    $display("Run covered %0d readings and %0d compensations under %0d calibration sets,",
             n_in, n_comp, n_cal_sets);
    $display("with %0d below 20.00 C and %0d below -15.00 C, checked against %0d results.",
             n_low, n_vlow, n_out);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
